@@ hw/rtl/ethernet_mac_register_block_core_assert.svh @@
// Assertion macros for the MAC register block.
// EMRB_ASSERT_SAME: consequent checked in the same cycle as the antecedent.
// EMRB_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef ETHERNET_MAC_REGISTER_BLOCK_CORE_ASSERT_SVH
`define ETHERNET_MAC_REGISTER_BLOCK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EMRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EMRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EMRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define EMRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/emrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package emrb_pkg;

    // store geometry
    localparam int REG_WORDS = 1148;
    localparam int PHY_DEPTH = 32;
    localparam int REG_AW    = $clog2(REG_WORDS);
    localparam int PHY_AW    = $clog2(PHY_DEPTH);

    // field widths
    localparam int OPC_W  = 2;
    localparam int OFS_W  = 13;
    localparam int SIZE_W = 3;
    localparam int DATA_W = 32;
    localparam int MAC_W  = 48;
    localparam int PHY_W  = 16;
    localparam int WORD_W = OFS_W - 2;

    // APB config port
    localparam int APB_AW = 4;
    localparam int APB_DW = 64;
    localparam logic CFG_DEFAULT_MAC = 1'b0;
    localparam logic [MAC_W-1:0] MAC_RESET = 48'h0000_0000_0002;

    // opcodes
    localparam logic [OPC_W-1:0] OP_READ  = 2'd0;
    localparam logic [OPC_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OPC_W-1:0] OP_EVENT = 2'd2;

    localparam logic [SIZE_W-1:0] ACC_SIZE = 3'd4;

    localparam logic [OFS_W:0] OFS_LIMIT = (OFS_W + 1)'(REG_WORDS * 4);
    localparam logic [REG_AW-1:0] CLR_LAST = REG_AW'(REG_WORDS - 1);

    // register offsets
    localparam logic [OFS_W-1:0] OFS_MDIOAR = 13'h0200;
    localparam logic [OFS_W-1:0] OFS_MDIODR = 13'h0204;
    localparam logic [OFS_W-1:0] OFS_MACHI  = 13'h0300;
    localparam logic [OFS_W-1:0] OFS_MACLO  = 13'h0304;
    localparam logic [OFS_W-1:0] OFS_DMAMR  = 13'h1000;
    localparam logic [OFS_W-1:0] OFS_DMAISR = 13'h1008;
    localparam logic [OFS_W-1:0] OFS_DMAIER = 13'h1134;
    localparam logic [OFS_W-1:0] OFS_DMASR  = 13'h1160;

    localparam logic [WORD_W-1:0] W_MDIOAR = OFS_MDIOAR[OFS_W-1:2];
    localparam logic [WORD_W-1:0] W_MDIODR = OFS_MDIODR[OFS_W-1:2];
    localparam logic [WORD_W-1:0] W_MACHI  = OFS_MACHI[OFS_W-1:2];
    localparam logic [WORD_W-1:0] W_MACLO  = OFS_MACLO[OFS_W-1:2];
    localparam logic [WORD_W-1:0] W_DMAMR  = OFS_DMAMR[OFS_W-1:2];
    localparam logic [WORD_W-1:0] W_DMAISR = OFS_DMAISR[OFS_W-1:2];
    localparam logic [WORD_W-1:0] W_DMAIER = OFS_DMAIER[OFS_W-1:2];
    localparam logic [WORD_W-1:0] W_DMASR  = OFS_DMASR[OFS_W-1:2];

    // with a short store the status word is gone and events are dropped
    localparam logic DMASR_PRESENT = (int'(W_DMASR) < REG_WORDS);

    // DMA status / interrupt enable bits
    localparam logic [DATA_W-1:0] ST_EVENT_MASK    = 32'h0000_00C1;
    localparam logic [DATA_W-1:0] ST_NORMAL_MASK   = 32'h0000_0045;
    localparam logic [DATA_W-1:0] ST_ABNORMAL_MASK = 32'h0000_0080;
    localparam int IE_AIE_BIT = 14;
    localparam int IE_NIE_BIT = 15;

    // MDIO operation codes
    localparam logic [1:0] MDIO_OP_WRITE = 2'd1;
    localparam logic [1:0] MDIO_OP_READ  = 2'd3;

    // PHY registers
    localparam logic [PHY_AW-1:0] PHY_BCR    = 5'd0;
    localparam logic [PHY_AW-1:0] PHY_BSR    = 5'd1;
    localparam logic [PHY_AW-1:0] PHY_ID1    = 5'd2;
    localparam logic [PHY_AW-1:0] PHY_ID2    = 5'd3;
    localparam logic [PHY_AW-1:0] PHY_ADV    = 5'd4;
    localparam logic [PHY_AW-1:0] PHY_LP_ADV = 5'd5;
    localparam logic [PHY_AW-1:0] PHY_SCSR   = 5'd31;

    localparam logic [PHY_W-1:0] BCR_SOFT_RESET = 16'h8000;
    localparam logic [PHY_W-1:0] BCR_AN_RESTART = 16'h0200;
    localparam logic [PHY_W-1:0] BSR_LINK_SET   = 16'h002C;
    localparam logic [PHY_W-1:0] BSR_LINK_CLR   = 16'h0024;
    localparam logic [PHY_W-1:0] SCSR_LINK_SET  = 16'h1018;
    localparam logic [PHY_W-1:0] SCSR_LINK_CLR  = 16'h0004;
    localparam logic [PHY_W-1:0] SCSR_DOWN_CLR  = 16'h101C;

    function automatic logic [PHY_W-1:0] phy_default(input logic [PHY_AW-1:0] ra);
        logic [PHY_W-1:0] v;
        v = '0;
        case (ra) inside
            PHY_BCR:             v = 16'h1000;
            PHY_BSR:             v = 16'h7808;
            PHY_ID1:             v = 16'h0007;
            PHY_ID2:             v = 16'hC0F0;
            PHY_ADV, PHY_LP_ADV: v = 16'h01E1;
            default:             v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/emrb_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface emrb_req_if;
    import emrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [OFS_W-1:0]  byte_offset;
    logic [SIZE_W-1:0] access_size;
    logic [DATA_W-1:0] write_data;
    logic              link_up;
    logic              clock_on;

    modport source (
        output valid, opcode, byte_offset, access_size, write_data, link_up, clock_on,
        input  ready
    );
    modport sink (
        input  valid, opcode, byte_offset, access_size, write_data, link_up, clock_on,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/emrb_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface emrb_rsp_if;
    import emrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              bus_ok;
    logic              irq_pulse;

    modport source (
        output valid, read_data, bus_ok, irq_pulse,
        input  ready
    );
    modport sink (
        input  valid, read_data, bus_ok, irq_pulse,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/emrb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port RAM, registered read
module emrb_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

@@ hw/rtl/ethernet_mac_register_block_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "ethernet_mac_register_block_core_assert.svh"

// Channel   Dir  Handshake                Payload
// i_req     in   valid/ready              opcode, byte_offset, access_size, write_data,
//                                         link_up, clock_on
// o_rsp     out  valid/ready              read_data, bus_ok, irq_pulse
// APB       in   psel/penable/pwrite      paddr 0: default_mac (48 bits in 64-bit pwdata)
//
// Each transaction is accepted in S_IDLE and committed in S_EXEC: the accept edge launches
// the reads of the register RAM and the PHY RAM, the commit edge does the read-modify-write
// and loads the result register. A new transaction is taken only after the last one commits.
// A result waiting in o_rsp still lets the next transaction in; only its commit waits.
// i_rst_n is synchronous, active low. After reset, and after a DMAMR software reset,
// the register RAM is swept to zero, all REG_WORDS (1148) words, with i_req.ready low.
module ethernet_mac_register_block_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    emrb_req_if.sink                           i_req,
    emrb_rsp_if.source                         o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [emrb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [emrb_pkg::APB_DW-1:0]   pwdata,
    output logic      [emrb_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import emrb_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic [REG_AW-1:0] r_clr_addr, n_clr_addr;

    // captured transaction
    logic [OPC_W-1:0]  r_op;
    logic [OFS_W-1:0]  r_ofs;
    logic [SIZE_W-1:0] r_sz;
    logic [DATA_W-1:0] r_data;
    logic              r_link;
    logic              r_clkon;

    // registers with side effects live in flops, the rest in the RAM
    logic [DATA_W-1:0] r_mdioar, n_mdioar;
    logic [DATA_W-1:0] r_mdiodr, n_mdiodr;
    logic [DATA_W-1:0] r_machi,  n_machi;
    logic [DATA_W-1:0] r_maclo,  n_maclo;
    logic [DATA_W-1:0] r_dmamr,  n_dmamr;
    logic [DATA_W-1:0] r_dmaisr, n_dmaisr;
    logic [DATA_W-1:0] r_dmaier, n_dmaier;
    logic [DATA_W-1:0] r_dmasr,  n_dmasr;

    // PHY entry not valid -> reads its default
    logic [PHY_DEPTH-1:0] r_phy_vld, n_phy_vld;

    logic              r_out_vld, n_out_vld;
    logic [DATA_W-1:0] r_rd_data, n_rd_data;
    logic              r_bus_ok,  n_bus_ok;
    logic              r_irq,     n_irq;

    logic [MAC_W-1:0] r_default_mac;

    logic acc, cm, cfg_wr;
    logic [WORD_W-1:0] word;
    logic in_range, size_ok;

    // MDIO decode of the effective MDIOAR value
    logic [DATA_W-1:0] ar;
    logic [4:0]        m_pa;
    logic [1:0]        m_op;
    logic [PHY_AW-1:0] m_ra;
    logic [PHY_W-1:0]  m_wval;
    logic [PHY_W-1:0]  phy_raw, phy_val;

    logic [PHY_AW-1:0] phy_raddr;
    logic [PHY_W-1:0]  phy_rdata;
    logic              phy_we;
    logic [PHY_W-1:0]  phy_wdata;

    logic              ram_we;
    logic [REG_AW-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    logic srst, mdio_go, irq_chk, rd_go, plain_wr;
    logic [DATA_W-1:0] ie_hit;

    // ---------------- handshakes ----------------
    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign cm          = (r_state == S_EXEC) && (!r_out_vld || o_rsp.ready);

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.read_data = r_rd_data;
    assign o_rsp.bus_ok    = r_bus_ok;
    assign o_rsp.irq_pulse = r_irq;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[APB_AW-1] == CFG_DEFAULT_MAC);
    assign prdata = (paddr[APB_AW-1] == CFG_DEFAULT_MAC) ?
                    {{(APB_DW - MAC_W){1'b0}}, r_default_mac} : '0;

    // ---------------- memories ----------------
    // PHY register addressed by the MDIOAR value this transaction will run with
    assign phy_raddr = (i_req.opcode == OP_WRITE) ? i_req.write_data[16 +: PHY_AW]
                                                  : r_mdioar[16 +: PHY_AW];

    emrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_WORDS)
    ) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (acc),
        .i_raddr (i_req.byte_offset[REG_AW+1:2]),
        .o_rdata (ram_rdata)
    );

    emrb_ram #(
        .WIDTH (PHY_W),
        .DEPTH (PHY_DEPTH)
    ) u_phy_ram (
        .i_clk   (i_clk),
        .i_we    (phy_we),
        .i_waddr (m_ra),
        .i_wdata (phy_wdata),
        .i_re    (acc),
        .i_raddr (phy_raddr),
        .o_rdata (phy_rdata)
    );

    // ---------------- transaction decode ----------------
    assign word     = r_ofs[OFS_W-1:2];
    assign in_range = ({1'b0, r_ofs} < OFS_LIMIT);
    assign size_ok  = (r_sz == ACC_SIZE);

    // MDIOAR write runs with the new value, MDIOAR read with the stored one
    assign ar     = (r_op == OP_WRITE) ? r_data : r_mdioar;
    assign m_pa   = ar[25:21];
    assign m_op   = ar[3:2];
    assign m_ra   = ar[16 +: PHY_AW];
    assign m_wval = r_mdiodr[PHY_W-1:0];

    assign phy_raw   = r_phy_vld[m_ra] ? phy_rdata : phy_default(m_ra);
    // BCR auto-negotiation restart always reads back clear
    assign phy_wdata = (m_ra == PHY_BCR) ? (m_wval & ~BCR_AN_RESTART) : m_wval;

    // link state folds into BSR and the special status register on reads
    always_comb begin
        phy_val = phy_raw;
        if (m_ra == PHY_BSR) begin
            phy_val = r_link ? (phy_raw | BSR_LINK_SET) : (phy_raw & ~BSR_LINK_CLR);
        end else if (m_ra == PHY_SCSR) begin
            phy_val = r_link ? ((phy_raw | SCSR_LINK_SET) & ~SCSR_LINK_CLR)
                             : (phy_raw & ~SCSR_DOWN_CLR);
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_mdioar   = r_mdioar;
        n_mdiodr   = r_mdiodr;
        n_machi    = r_machi;
        n_maclo    = r_maclo;
        n_dmamr    = r_dmamr;
        n_dmaisr   = r_dmaisr;
        n_dmaier   = r_dmaier;
        n_dmasr    = r_dmasr;
        n_phy_vld  = r_phy_vld;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_rd_data  = r_rd_data;
        n_bus_ok   = r_bus_ok;
        n_irq      = r_irq;

        ram_we    = 1'b0;
        ram_waddr = r_ofs[REG_AW+1:2];
        ram_wdata = r_data;
        phy_we    = 1'b0;
        srst      = 1'b0;
        mdio_go   = 1'b0;
        irq_chk   = 1'b0;
        rd_go     = 1'b0;
        plain_wr  = 1'b0;
        ie_hit    = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cm) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_rd_data = '0;
                    n_bus_ok  = 1'b0;
                    n_irq     = 1'b0;

                    case (r_op)
                        OP_READ: begin
                            // clock off answers ok even for a bad offset
                            if (size_ok && (!r_clkon || in_range)) begin
                                n_bus_ok = 1'b1;
                            end
                            if (size_ok && r_clkon && in_range) begin
                                rd_go   = 1'b1;
                                mdio_go = (r_ofs == OFS_MDIOAR);
                                if (r_ofs == OFS_MACHI) begin
                                    n_machi = {16'h0, r_machi[15:0]};
                                end
                            end
                        end
                        OP_WRITE: begin
                            if (size_ok && in_range) begin
                                n_bus_ok = 1'b1;
                                if (r_clkon) begin
                                    if ((r_ofs == OFS_DMAMR) && r_data[0]) begin
                                        srst = 1'b1;
                                    end else if (r_ofs == OFS_DMASR) begin
                                        n_dmasr = r_dmasr & ~r_data;  // W1C
                                        irq_chk = 1'b1;
                                    end else if (r_ofs == OFS_MDIOAR) begin
                                        mdio_go = 1'b1;
                                    end else begin
                                        plain_wr = 1'b1;
                                    end
                                end
                            end
                        end
                        OP_EVENT: begin
                            n_bus_ok = 1'b1;
                            if (r_clkon) begin
                                if (DMASR_PRESENT) begin
                                    n_dmasr = r_dmasr | (r_data & ST_EVENT_MASK);
                                end
                                irq_chk = 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    if (plain_wr) begin
                        case (word)
                            W_MDIOAR: n_mdioar = r_data;
                            W_MDIODR: n_mdiodr = r_data;
                            W_MACHI:  n_machi  = r_data;
                            W_MACLO:  n_maclo  = r_data;
                            W_DMAMR:  n_dmamr  = r_data;
                            W_DMAISR: n_dmaisr = r_data;
                            W_DMAIER: n_dmaier = r_data;
                            W_DMASR:  n_dmasr  = r_data;
                            default:  ram_we   = 1'b1;
                        endcase
                    end

                    // MDIO frame against the PHY store; busy drops afterwards
                    if (mdio_go) begin
                        n_mdioar = ar & ~32'h1;
                        if (ar[0]) begin
                            if (m_pa != '0) begin
                                n_mdiodr = 32'h0000_FFFF;  // no PHY at that address
                            end else if (m_op == MDIO_OP_READ) begin
                                n_mdiodr = {16'h0, phy_val};
                            end else if (m_op == MDIO_OP_WRITE) begin
                                if ((m_ra == PHY_BCR) && ((m_wval & BCR_SOFT_RESET) != '0)) begin
                                    n_phy_vld = '0;  // PHY soft reset: back to defaults
                                end else begin
                                    phy_we          = 1'b1;
                                    n_phy_vld[m_ra] = 1'b1;
                                end
                            end
                        end
                    end

                    if (irq_chk) begin
                        ie_hit = n_dmasr & r_dmaier;
                        if ((((ie_hit & ST_NORMAL_MASK) != '0) && r_dmaier[IE_NIE_BIT]) ||
                            (((ie_hit & ST_ABNORMAL_MASK) != '0) && r_dmaier[IE_AIE_BIT])) begin
                            n_dmaisr = r_dmaisr | 32'h1;
                            n_irq    = 1'b1;
                        end
                    end

                    if (srst) begin
                        n_state    = S_CLEAR;
                        n_clr_addr = '0;
                        n_mdioar   = '0;
                        n_mdiodr   = '0;
                        n_machi    = {16'h0, r_default_mac[47:32]};
                        n_maclo    = r_default_mac[31:0];
                        n_dmamr    = '0;
                        n_dmaisr   = '0;
                        n_dmaier   = '0;
                        n_dmasr    = '0;
                        n_phy_vld  = '0;
                    end

                    // read returns the word after this transaction's side effects
                    if (rd_go) begin
                        case (word)
                            W_MDIOAR: n_rd_data = n_mdioar;
                            W_MDIODR: n_rd_data = n_mdiodr;
                            W_MACHI:  n_rd_data = n_machi;
                            W_MACLO:  n_rd_data = n_maclo;
                            W_DMAMR:  n_rd_data = n_dmamr;
                            W_DMAISR: n_rd_data = n_dmaisr;
                            W_DMAIER: n_rd_data = n_dmaier;
                            W_DMASR:  n_rd_data = n_dmasr;
                            default:  n_rd_data = ram_rdata;
                        endcase
                    end
                end
            end
            default: begin
                n_state    = S_CLEAR;
                n_clr_addr = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op    <= i_req.opcode;
            r_ofs   <= i_req.byte_offset;
            r_sz    <= i_req.access_size;
            r_data  <= i_req.write_data;
            r_link  <= i_req.link_up;
            r_clkon <= i_req.clock_on;
        end
        r_rd_data <= n_rd_data;
        r_bus_ok  <= n_bus_ok;
        r_irq     <= n_irq;

        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_mdioar      <= '0;
            r_mdiodr      <= '0;
            r_machi       <= {16'h0, MAC_RESET[47:32]};
            r_maclo       <= MAC_RESET[31:0];
            r_dmamr       <= '0;
            r_dmaisr      <= '0;
            r_dmaier      <= '0;
            r_dmasr       <= '0;
            r_phy_vld     <= '0;
            r_out_vld     <= 1'b0;
            r_default_mac <= MAC_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_mdioar   <= n_mdioar;
            r_mdiodr   <= n_mdiodr;
            r_machi    <= n_machi;
            r_maclo    <= n_maclo;
            r_dmamr    <= n_dmamr;
            r_dmaisr   <= n_dmaisr;
            r_dmaier   <= n_dmaier;
            r_dmasr    <= n_dmasr;
            r_phy_vld  <= n_phy_vld;
            r_out_vld  <= n_out_vld;
            if (cfg_wr) begin
                r_default_mac <= pwdata[MAC_W-1:0];
            end
        end
    end

    // ---------------- assertions ----------------
    `EMRB_ASSERT_NEXT(a_srst_reload, i_clk, i_rst_n, cm && srst, (r_state == S_CLEAR) && (r_maclo == $past(r_default_mac[31:0])), "soft reset did not start sweep with MAC reload")
    `EMRB_ASSERT_NEXT(a_irq_sets_isr, i_clk, i_rst_n, cm && n_irq, r_dmaisr[0], "interrupt raised without DMAISR flag")
    `EMRB_ASSERT_SAME(a_ram_addr, i_clk, i_rst_n, ram_we, ram_waddr <= CLR_LAST, "register RAM write beyond store")

endmodule

`default_nettype wire

@@ tb/ethernet_mac_register_block_core_test.sv @@
`timescale 1ns / 1ps

module ethernet_mac_register_block_core_test;
    import emrb_pkg::*;

    // opcode with no meaning: the block must answer it with bus_ok low
    localparam logic [OPC_W-1:0]  OP_UNUSED        = 2'd3;
    // default_mac is register 0; 48 bits wide, so registers sit 8 bytes apart
    localparam logic [APB_AW-1:0] ADDR_DEFAULT_MAC = APB_AW'(8 * int'(CFG_DEFAULT_MAC));
    localparam logic [DATA_W-1:0] DMAMR_SWR        = 32'h0000_0001;
    localparam logic [DATA_W-1:0] MDIOAR_BUSY      = 32'h0000_0001;
    localparam logic [DATA_W-1:0] DMAISR_DC0IS    = 32'h0000_0001;
    localparam logic [DATA_W-1:0] IE_MASK          = ST_NORMAL_MASK | ST_ABNORMAL_MASK |
                                                     (32'h1 << IE_AIE_BIT) |
                                                     (32'h1 << IE_NIE_BIT);

    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 500;
    // long enough to outlast a store sweep (after reset or DMAMR.SWR), which closes the request side
    localparam int SWEEP_WAIT  = REG_WORDS + 100;
    localparam int TAIL_WAIT   = 50;
    // several times the worst quiet stretch: one sweep plus the longest stall
    localparam int QUIET_LIMIT = 20000;
    localparam int REPORT_CAP  = 50;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [OFS_W-1:0]  byte_offset;
        logic [SIZE_W-1:0] access_size;
        logic [DATA_W-1:0] write_data;
        logic              link_up;
        logic              clock_on;
    } t_bus_access;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bus_ok;
        logic              irq_pulse;
    } t_bus_reply;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    emrb_req_if req_bus ();
    emrb_rsp_if rsp_bus ();

    ethernet_mac_register_block_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the register side: register store, PHY file and
    // the configured MAC address that a software reset reloads.
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] shadow_regs [REG_WORDS];
    logic [PHY_W-1:0]  shadow_phy  [PHY_DEPTH];
    logic [MAC_W-1:0]  shadow_mac;

    t_bus_access bus_backlog[$];      // items waiting for the driver
    t_bus_reply  pending_replies[$];  // predicted replies, oldest first

    int  live_items;
    int  n_accepted;
    int  n_checked;
    int  n_sw_resets;
    int  n_mdio_runs;
    int  n_irqs;
    int  mismatch_count;
    int  quiet_cycles;
    int  req_gap;
    int  rsp_hold;
    bit  req_idling;
    bit  rsp_idling;
    bit  req_took;
    bit  rsp_took;

    function automatic logic [DATA_W-1:0] shadow_get(input logic [OFS_W-1:0] ofs);
        int w;
        w = int'(ofs) >> 2;
        return (w < REG_WORDS) ? shadow_regs[w] : '0;
    endfunction

    function automatic void shadow_put(input logic [OFS_W-1:0] ofs,
                                       input logic [DATA_W-1:0] value);
        int w;
        w = int'(ofs) >> 2;
        if (w < REG_WORDS) shadow_regs[w] = value;
    endfunction

    function automatic void phy_power_on();
        foreach (shadow_phy[i]) shadow_phy[i] = '0;
        shadow_phy[PHY_BCR]    = 16'h1000;
        shadow_phy[PHY_BSR]    = 16'h7808;
        shadow_phy[PHY_ID1]    = 16'h0007;
        shadow_phy[PHY_ID2]    = 16'hC0F0;
        shadow_phy[PHY_ADV]    = 16'h01E1;
        shadow_phy[PHY_LP_ADV] = 16'h01E1;
    endfunction

    // store cleared, MAC words loaded from the configured address, PHY defaults
    function automatic void store_reload();
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        shadow_put(OFS_MACHI, {16'h0, shadow_mac[47:32]});
        shadow_put(OFS_MACLO, shadow_mac[31:0]);
        phy_power_on();
    endfunction

    // summary interrupt: sets DMAISR bit 0 and reports a pulse
    function automatic logic dma_irq_eval();
        logic [DATA_W-1:0] sr;
        logic [DATA_W-1:0] ie;
        logic [DATA_W-1:0] hit;
        logic              normal;
        logic              abnormal;
        sr       = shadow_get(OFS_DMASR);
        ie       = shadow_get(OFS_DMAIER);
        hit      = sr & ie;
        normal   = |(hit & ST_NORMAL_MASK);
        abnormal = |(hit & ST_ABNORMAL_MASK);
        if ((normal && ie[IE_NIE_BIT]) || (abnormal && ie[IE_AIE_BIT])) begin
            shadow_put(OFS_DMAISR, shadow_get(OFS_DMAISR) | DMAISR_DC0IS);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // runs whatever MDIOAR holds, if busy is set
    function automatic void mdio_exec(input logic link);
        logic [DATA_W-1:0] ar;
        logic [DATA_W-1:0] dr;
        logic [PHY_W-1:0]  v;
        logic [PHY_AW-1:0] ra;
        logic [4:0]        pa;
        logic [1:0]        op;
        ar = shadow_get(OFS_MDIOAR);
        if ((ar & MDIOAR_BUSY) == '0) return;
        n_mdio_runs++;
        op = ar[3:2];
        ra = ar[20:16];
        pa = ar[25:21];
        if (pa != 5'd0) begin
            // nobody answers at another PHY address
            shadow_put(OFS_MDIODR, 32'h0000_FFFF);
        end else if (op == MDIO_OP_READ) begin
            v = shadow_phy[ra];
            if (ra == PHY_BSR) begin
                v = link ? (v | BSR_LINK_SET) : (v & ~BSR_LINK_CLR);
            end else if (ra == PHY_SCSR) begin
                v = link ? ((v | SCSR_LINK_SET) & ~SCSR_LINK_CLR) : (v & ~SCSR_DOWN_CLR);
            end
            shadow_put(OFS_MDIODR, {16'h0, v});
        end else if (op == MDIO_OP_WRITE) begin
            dr = shadow_get(OFS_MDIODR);
            v  = dr[PHY_W-1:0];
            shadow_phy[ra] = v;
            if (ra == PHY_BCR) begin
                if ((v & BCR_SOFT_RESET) != '0) begin
                    phy_power_on();
                    shadow_phy[PHY_BCR] = shadow_phy[PHY_BCR] & ~BCR_SOFT_RESET;
                end
                if ((v & BCR_AN_RESTART) != '0) begin
                    shadow_phy[PHY_BCR] = shadow_phy[PHY_BCR] & ~BCR_AN_RESTART;
                end
            end
        end
        shadow_put(OFS_MDIOAR, shadow_get(OFS_MDIOAR) & ~MDIOAR_BUSY);
    endfunction

    function automatic t_bus_reply predict_reply(input t_bus_access a);
        t_bus_reply r;
        logic       sized;
        logic       fits;
        r     = '0;
        sized = (a.access_size == ACC_SIZE);
        fits  = ({1'b0, a.byte_offset} < OFS_LIMIT);
        case (a.opcode)
            OP_READ: begin
                if (sized && !a.clock_on) begin
                    // clock gated: reads answer zero, even out of range
                    r.bus_ok = 1'b1;
                end else if (sized && fits) begin
                    r.bus_ok = 1'b1;
                    if (a.byte_offset == OFS_MDIOAR) mdio_exec(a.link_up);
                    if (a.byte_offset == OFS_MACHI) begin
                        shadow_put(OFS_MACHI, shadow_get(OFS_MACHI) & 32'h0000_FFFF);
                    end
                    r.read_data = shadow_get(a.byte_offset);
                end
            end
            OP_WRITE: begin
                if (sized && fits) begin
                    r.bus_ok = 1'b1;
                    if (a.clock_on) begin
                        if (a.byte_offset == OFS_DMAMR) begin
                            if ((a.write_data & DMAMR_SWR) != '0) begin
                                n_sw_resets++;
                                store_reload();
                            end else begin
                                shadow_put(a.byte_offset, a.write_data);
                            end
                        end else if (a.byte_offset == OFS_DMASR) begin
                            // write one to clear
                            shadow_put(OFS_DMASR, shadow_get(OFS_DMASR) & ~a.write_data);
                            r.irq_pulse = dma_irq_eval();
                        end else if (a.byte_offset == OFS_MDIOAR) begin
                            shadow_put(a.byte_offset, a.write_data);
                            mdio_exec(a.link_up);
                        end else begin
                            shadow_put(a.byte_offset, a.write_data);
                        end
                    end
                end
            end
            OP_EVENT: begin
                r.bus_ok = 1'b1;
                if (a.clock_on) begin
                    shadow_put(OFS_DMASR,
                               shadow_get(OFS_DMASR) | (a.write_data & ST_EVENT_MASK));
                    r.irq_pulse = dma_irq_eval();
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_bus_access make_access(input logic [OPC_W-1:0]  op,
                                                input logic [OFS_W-1:0]  ofs,
                                                input logic [DATA_W-1:0] data,
                                                input logic [SIZE_W-1:0] size,
                                                input logic              link,
                                                input logic              clk_en);
        t_bus_access a;
        a.opcode      = op;
        a.byte_offset = ofs;
        a.access_size = size;
        a.write_data  = data;
        a.link_up     = link;
        a.clock_on    = clk_en;
        return a;
    endfunction

    // well-formed access that now and then has the clock off or a bad size
    function automatic t_bus_access rough_access(input logic [OPC_W-1:0]  op,
                                                 input logic [OFS_W-1:0]  ofs,
                                                 input logic [DATA_W-1:0] data);
        t_bus_access a;
        int          roll;
        roll = $urandom_range(0, 99);
        a    = make_access(op, ofs, data, ACC_SIZE, 1'($urandom), 1'b1);
        if (roll < 3) a.clock_on = 1'b0;
        else if (roll < 5) a.access_size = a.access_size ^ SIZE_W'($urandom_range(1, 7));
        return a;
    endfunction

    task automatic queue_access(input t_bus_access a);
        bus_backlog.push_back(a);
        // only well-sized, clocked transactions with a used opcode count toward a phase
        if (a.access_size == ACC_SIZE && a.clock_on && a.opcode != OP_UNUSED) live_items++;
    endtask

    task automatic queue_sw_reset();
        logic [DATA_W-1:0] data;
        data = $urandom;
        data = data | DMAMR_SWR;
        queue_access(make_access(OP_WRITE, OFS_DMAMR, data, ACC_SIZE, 1'($urandom), 1'b1));
        queue_access(rough_access(OP_READ, OFS_MACHI, $urandom));
        queue_access(rough_access(OP_READ, OFS_MACLO, $urandom));
    endtask

    // set up MDIODR/MDIOAR, trigger, then read both back
    task automatic queue_mdio_burst();
        logic [DATA_W-1:0] ar;
        logic [4:0]        pa;
        logic [4:0]        ra;
        int                pick;
        pa   = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(1, 31)) : 5'd0;
        pick = $urandom_range(0, 4);
        ra   = (pick == 0) ? PHY_BCR : (pick == 1) ? PHY_BSR :
               (pick == 2) ? PHY_SCSR : 5'($urandom);
        ar   = $urandom;
        ar[25:21] = pa;
        ar[20:16] = ra;
        pick = $urandom_range(0, 9);
        ar[3:2] = (pick < 4) ? MDIO_OP_READ : (pick < 8) ? MDIO_OP_WRITE : 2'($urandom);
        ar = ($urandom_range(0, 7) != 0) ? (ar | MDIOAR_BUSY) : (ar & ~MDIOAR_BUSY);
        if ($urandom_range(0, 1) != 0) queue_access(rough_access(OP_WRITE, OFS_MDIODR, $urandom));
        if ($urandom_range(0, 3) == 0) begin
            // unaligned store of MDIOAR does not start it; the read below does
            queue_access(rough_access(OP_WRITE, OFS_MDIOAR + 13'd1, ar));
        end else begin
            queue_access(rough_access(OP_WRITE, OFS_MDIOAR, ar));
        end
        queue_access(rough_access(OP_READ, OFS_MDIOAR, $urandom));
        queue_access(rough_access(OP_READ, OFS_MDIODR, $urandom));
    endtask

    // enables, a few status events, status readback, W1C, summary readback
    task automatic queue_irq_burst();
        logic [DATA_W-1:0] ie;
        logic [DATA_W-1:0] clr;
        ie = $urandom;
        if ($urandom_range(0, 3) != 0) ie = ie & IE_MASK;
        if ($urandom_range(0, 2) != 0) queue_access(rough_access(OP_WRITE, OFS_DMAIER, ie));
        repeat ($urandom_range(1, 3)) begin
            queue_access(rough_access(OP_EVENT, OFS_W'($urandom), $urandom));
        end
        queue_access(rough_access(OP_READ, OFS_DMASR, $urandom));
        queue_access(rough_access(OP_READ, OFS_DMAISR, $urandom));
        clr = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
        queue_access(rough_access(OP_WRITE, OFS_DMASR, clr));
        if ($urandom_range(0, 1) != 0) queue_access(rough_access(OP_WRITE, OFS_DMAISR, '0));
        queue_access(rough_access(OP_READ, OFS_DMAISR, $urandom));
    endtask

    task automatic queue_plain_burst();
        logic [OFS_W-1:0]  ofs;
        logic [DATA_W-1:0] data;
        logic [OPC_W-1:0]  op;
        case ($urandom_range(0, 9))
            0: ofs = OFS_MACHI;
            1: ofs = OFS_MACLO;
            2: ofs = OFS_DMAMR;
            3: ofs = OFS_DMAISR;
            4: ofs = OFS_DMAIER;
            5: ofs = OFS_DMASR;
            6: ofs = OFS_MDIODR;
            7: ofs = OFS_W'($urandom_range(0, REG_WORDS - 1) * 4);
            8: ofs = OFS_W'($urandom_range(0, REG_WORDS * 4 - 1));
            default: ofs = OFS_W'(OFS_LIMIT - 4);
        endcase
        data = $urandom;
        // software resets are paced by their own burst
        if (ofs == OFS_DMAMR) data = data & ~DMAMR_SWR;
        op = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
        queue_access(rough_access(op, ofs, data));
        if (op == OP_WRITE) queue_access(rough_access(OP_READ, ofs, $urandom));
    endtask

    task automatic queue_random_burst();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            queue_mdio_burst();
        end else if (roll < 50) begin
            queue_irq_burst();
        end else if (roll < 75) begin
            queue_plain_burst();
        end else if (roll < 78) begin
            queue_sw_reset();
        end else begin
            // anything the fields allow
            queue_access(make_access(OPC_W'($urandom), OFS_W'($urandom), $urandom,
                                     SIZE_W'($urandom), 1'($urandom), 1'($urandom)));
        end
    endtask

    // corner cases, run once right after reset with the reset MAC address
    task automatic queue_directed();
        queue_access(make_access(OP_READ,  OFS_MACHI, '0, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_READ,  OFS_MACLO, '0, ACC_SIZE, 1'b1, 1'b1));
        // bad sizes
        queue_access(make_access(OP_READ,  OFS_MACLO, '0, 3'd0, 1'b0, 1'b1));
        queue_access(make_access(OP_WRITE, '0, '1, 3'd7, 1'b1, 1'b1));
        // past the end of the region, clock on and off
        queue_access(make_access(OP_READ,  '1, '0, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_READ,  '1, '0, ACC_SIZE, 1'b0, 1'b0));
        queue_access(make_access(OP_WRITE, OFS_W'(OFS_LIMIT), '1, ACC_SIZE, 1'b0, 1'b1));
        // last word of the store
        queue_access(make_access(OP_WRITE, OFS_W'(OFS_LIMIT - 4), '1, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_READ,  OFS_W'(OFS_LIMIT - 4), '0, ACC_SIZE, 1'b1, 1'b1));
        queue_access(make_access(OP_UNUSED, OFS_MACLO, '1, ACC_SIZE, 1'b1, 1'b1));
        // unaligned write fills the MAC high word; exact read truncates it
        queue_access(make_access(OP_WRITE, OFS_MACHI + 13'd3, '1, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_READ,  OFS_MACHI, '0, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_READ,  OFS_MACHI + 13'd2, '0, ACC_SIZE, 1'b0, 1'b1));
        // clock gated write is dropped
        queue_access(make_access(OP_WRITE, '0, '1, ACC_SIZE, 1'b0, 1'b0));
        queue_access(make_access(OP_READ,  '0, '0, ACC_SIZE, 1'b0, 1'b1));
        // MDIO: BSR read with link up, BCR write with reset and restart, foreign PHY
        queue_access(make_access(OP_WRITE, OFS_MDIOAR, 32'h0001_000D, ACC_SIZE, 1'b1, 1'b1));
        queue_access(make_access(OP_READ,  OFS_MDIODR, '0, ACC_SIZE, 1'b1, 1'b1));
        queue_access(make_access(OP_WRITE, OFS_MDIODR, 32'h0000_8200, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_WRITE, OFS_MDIOAR, 32'h0000_0005, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_WRITE, OFS_MDIOAR, 32'h0020_000D, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_READ,  OFS_MDIODR, '0, ACC_SIZE, 1'b0, 1'b1));
        // interrupts: all enables, event with every bit set, clear all, summary
        queue_access(make_access(OP_WRITE, OFS_DMAIER, IE_MASK, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_EVENT, '1, '1, 3'd0, 1'b0, 1'b1));
        queue_access(make_access(OP_WRITE, OFS_DMASR, '1, ACC_SIZE, 1'b0, 1'b1));
        queue_access(make_access(OP_READ,  OFS_DMAISR, '0, ACC_SIZE, 1'b0, 1'b1));
    endtask

    // APB write: setup, access, commit at the edge with pready high
    task automatic cfg_write(input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_DEFAULT_MAC;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_mac = value[MAC_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic settle();
        while (bus_backlog.size() != 0 || req_bus.valid || pending_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic int pick_gap(input bit idling);
        int roll;
        roll = $urandom_range(0, 99);
        if (!idling || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Request driver: changes at the falling edge, holds an item until
    // the rising edge that takes it, then idles for a random gap.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : drive_req
        t_bus_access cur;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (req_bus.valid && !req_took) begin
            // still waiting for ready
        end else if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap--;
        end else if (bus_backlog.size() != 0) begin
            cur = bus_backlog.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.opcode      <= cur.opcode;
            req_bus.byte_offset <= cur.byte_offset;
            req_bus.access_size <= cur.access_size;
            req_bus.write_data  <= cur.write_data;
            req_bus.link_up     <= cur.link_up;
            req_bus.clock_on    <= cur.clock_on;
            // switch between bursty stretches and back-to-back stretches
            if ($urandom_range(0, 149) == 0) req_idling = !req_idling;
            req_gap = pick_gap(req_idling);
        end else begin
            req_bus.valid <= 1'b0;
        end
    end

    // Reply side back-pressure, same mix of short and long stalls.
    always @(negedge i_clk) begin : drive_ready
        if ($urandom_range(0, 299) == 0) rsp_idling = !rsp_idling;
        if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
        end else begin
            rsp_bus.ready <= 1'b1;
            rsp_hold = pick_gap(rsp_idling);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: at each rising edge check a taken reply against the oldest
    // prediction, then predict the reply for a taken request. A watchdog
    // ends the run when neither side moves for too long.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_bus
        t_bus_access a;
        t_bus_reply  got;
        t_bus_reply  want;
        if (!i_rst_n) begin
            req_took     = 1'b0;
            rsp_took     = 1'b0;
            quiet_cycles = 0;
        end else begin
            req_took = req_bus.valid && req_bus.ready;
            rsp_took = rsp_bus.valid && rsp_bus.ready;
            if (rsp_took) begin
                got = {rsp_bus.read_data, rsp_bus.bus_ok, rsp_bus.irq_pulse};
                if (got.irq_pulse === 1'b1) n_irqs++;
                if (pending_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP) begin
                        $display("%0t: reply with nothing outstanding, got data %h ok %b irq %b",
                                 $time, got.read_data, got.bus_ok, got.irq_pulse);
                    end
                end else begin
                    want = pending_replies.pop_front();
                    n_checked++;
                    report_field("read_data", want.read_data, got.read_data);
                    report_field("bus_ok", DATA_W'(want.bus_ok), DATA_W'(got.bus_ok));
                    report_field("irq_pulse", DATA_W'(want.irq_pulse), DATA_W'(got.irq_pulse));
                end
            end
            if (req_took) begin
                a = {req_bus.opcode, req_bus.byte_offset, req_bus.access_size,
                     req_bus.write_data, req_bus.link_up, req_bus.clock_on};
                pending_replies.push_back(predict_reply(a));
                n_accepted++;
            end
            if (req_took || rsp_took) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d replies outstanding",
                         $time, QUIET_LIMIT, pending_replies.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Run: reset, then four MAC settings. Each later phase waits for the
    // block to drain and finish any sweep, programs default_mac, and
    // starts with a software reset so the new address is loaded.
    // ---------------------------------------------------------------
    initial begin : run
        logic [MAC_W-1:0] mac_plan [PHASES];
        int               target;

        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_bus.valid       = 1'b0;
        req_bus.opcode      = OP_READ;
        req_bus.byte_offset = '0;
        req_bus.access_size = '0;
        req_bus.write_data  = '0;
        req_bus.link_up     = 1'b0;
        req_bus.clock_on    = 1'b0;
        rsp_bus.ready       = 1'b0;
        req_gap             = 0;
        rsp_hold            = 0;
        req_idling          = 1'b1;
        rsp_idling          = 1'b1;

        mac_plan[0] = MAC_RESET;
        mac_plan[1] = '1;
        mac_plan[2] = '0;
        mac_plan[3] = MAC_W'({$urandom, $urandom});

        shadow_mac = MAC_RESET;
        store_reload();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                queue_directed();
            end else begin
                settle();
                repeat (SWEEP_WAIT) @(posedge i_clk);
                cfg_write(APB_DW'(mac_plan[phase]));
                queue_sw_reset();
            end
            target = live_items + PHASE_ITEMS;
            while (live_items < target) queue_random_burst();
        end

        settle();
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Checked %0d of %0d transactions over %0d MAC settings.",
                 n_checked, n_accepted, PHASES);
        $display("Seen: %0d software resets, %0d MDIO operations, %0d interrupt pulses.",
                 n_sw_resets, n_mdio_runs, n_irqs);
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
